[rtl/a2s_pkg.sv]
package a2s_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } arib_item_t;

    typedef struct packed {
        logic [7:0] first_out;
        logic [7:0] second_out;
        logic [1:0] byte_count;
    } sjis_char_t;

    localparam logic [7:0] SET_KANJI     = 8'h42;
    localparam logic [7:0] SET_ASCII     = 8'h4A;
    localparam logic [7:0] SET_HIRAGANA  = 8'h30;
    localparam logic [7:0] SET_KATAKANA  = 8'h31;
    localparam logic [7:0] SET_PROP_ALNUM = 8'h36;
    localparam logic [7:0] SET_PROP_HIRA = 8'h37;
    localparam logic [7:0] SET_PROP_KATA = 8'h38;
    localparam logic [7:0] SET_JISX_KATA = 8'h49;
    localparam logic [7:0] SET_JIS_KANJI1 = 8'h39;
    localparam logic [7:0] SET_JIS_KANJI2 = 8'h3A;
    localparam logic [7:0] SET_ADD_SYMBOL = 8'h3B;

    localparam logic [7:0] CODE_LS0      = 8'h0F;
    localparam logic [7:0] CODE_LS1      = 8'h0E;
    localparam logic [7:0] CODE_SS2      = 8'h19;
    localparam logic [7:0] CODE_SS3      = 8'h1D;
    localparam logic [7:0] CODE_ESC      = 8'h1B;
    localparam logic [7:0] CODE_SPACE    = 8'h20;
    localparam logic [7:0] CODE_DEL      = 8'h7F;

    localparam logic [7:0] ESC_LS2       = 8'h6E;
    localparam logic [7:0] ESC_LS3       = 8'h6F;
    localparam logic [7:0] ESC_LS1R      = 8'h7E;
    localparam logic [7:0] ESC_LS2R      = 8'h7D;
    localparam logic [7:0] ESC_LS3R      = 8'h7C;
    localparam logic [7:0] ESC_DESIG_G0  = 8'h28;
    localparam logic [7:0] ESC_DESIG_G1  = 8'h29;
    localparam logic [7:0] ESC_DESIG_G2  = 8'h2A;
    localparam logic [7:0] ESC_DESIG_G3  = 8'h2B;
    localparam logic [7:0] ESC_MULTIBYTE = 8'h24;
    localparam logic [7:0] ESC_DRCS      = 8'h20;

    localparam logic [7:0] SJIS_SYM_LEAD = 8'h81;
    localparam logic [7:0] SJIS_QUESTION = 8'h48;

    function automatic logic set_valid(input logic [7:0] s);
        return s == SET_KANJI || s == SET_ASCII || s == SET_HIRAGANA ||
               s == SET_KATAKANA || s == SET_PROP_ALNUM || s == SET_PROP_HIRA ||
               s == SET_PROP_KATA || s == SET_JISX_KATA || s == SET_JIS_KANJI1 ||
               s == SET_JIS_KANJI2 || s == SET_ADD_SYMBOL;
    endfunction

    function automatic logic [7:0] sym_trail(input logic [2:0] idx, input logic kata);
        logic [7:0] t;
        case (idx)
            3'd0:    t = kata ? 8'h52 : 8'h54;
            3'd1:    t = kata ? 8'h53 : 8'h55;
            3'd2:    t = 8'h5B;
            3'd3:    t = 8'h42;
            3'd4:    t = 8'h75;
            3'd5:    t = 8'h76;
            3'd6:    t = 8'h41;
            default: t = 8'h45;
        endcase
        return t;
    endfunction

    function automatic sjis_char_t kana(input logic [6:0] c, input logic kata);
        sjis_char_t r;
        logic [6:0] idx;
        idx = c - 7'h77;
        r.byte_count = 2'd2;
        if (c >= 7'h77) begin
            r.first_out  = 8'h81;
            r.second_out = sym_trail(idx[2:0], kata);
        end else if (!kata) begin
            if (c <= 7'h73) begin
                r.first_out  = 8'h82;
                r.second_out = {1'b0, c} + 8'h7E;
            end else begin
                r.first_out  = 8'h81;
                r.second_out = 8'h40;
            end
        end else begin
            r.first_out = 8'h83;
            if (c <= 7'h5F) begin
                r.second_out = {1'b0, c} + 8'h1F;
            end else begin
                r.second_out = {1'b0, c} + 8'h20;
            end
        end
        return r;
    endfunction

    function automatic sjis_char_t kanji(input logic [6:0] lead, input logic [7:0] trail);
        sjis_char_t r;
        logic [6:0] row;
        row = lead - 7'h21;
        r.byte_count = 2'd2;
        r.first_out  = {2'b00, row[6:1]} + ((lead <= 7'h5E) ? 8'h81 : 8'hC1);
        if (lead[0]) begin
            r.second_out = trail + ((trail <= 8'h5F) ? 8'h1F : 8'h20);
        end else begin
            r.second_out = trail + 8'h7E;
        end
        return r;
    endfunction

endpackage

[rtl/arib_to_sjis_text_decoder.sv]
// Converts an ARIB coded text string to Shift-JIS, one character per result.
// Requests arrive on the byte channel (byte_valid, byte_stall, byte_data), one
// ARIB byte each, with end_of_string set on the last byte of a string.
// Results leave on the char channel (char_valid, char_stall, char_data); each
// carries one or two Shift-JIS bytes and the byte count. Control bytes,
// escape sequences, spaces, kanji lead bytes and dropped bytes give no result.
// A request is taken into an input register, decoded by one pass of
// combinational logic once the output register is empty or being read, and
// its result is written to the output register, which drives char_valid.
// Unless char_stall holds a result, one request can be accepted in every cycle;
// the single decode pass through designation and invocation registers sets it.
// While the receiver holds char_stall, the result waits in the output
// register, one more request may wait in the input register, and byte_stall
// rises after that. A request whose end_of_string is set returns all
// designations, invocations and pending state to their reset values.
// Reset empties both registers and selects kanji in GL and hiragana in GR.
module arib_to_sjis_text_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  a2s_pkg::arib_item_t   byte_data,
    output logic                  char_valid,
    input  logic                  char_stall,
    output a2s_pkg::sjis_char_t   char_data
);
    import a2s_pkg::*;

    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_AFTER,
        ESC_FINAL,
        ESC_MULTI,
        ESC_SKIP
    } esc_stage_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_KANJI,
        PEND_SYMBOL
    } pend_kind_t;

    logic        in_valid_reg, in_valid_next;
    arib_item_t  in_data_reg, in_data_next;
    logic        out_valid_reg, out_valid_next;
    sjis_char_t  out_data_reg, out_data_next;

    logic [7:0]  desig_reg [4];
    logic [7:0]  desig_next [4];
    logic [7:0]  left_set_reg, left_set_next;
    logic [7:0]  right_set_reg, right_set_next;
    logic [7:0]  saved_left_reg, saved_left_next;
    logic        single_shift_reg, single_shift_next;
    esc_stage_t  esc_stage_reg, esc_stage_next;
    logic [1:0]  esc_target_reg, esc_target_next;
    pend_kind_t  pend_reg, pend_next;
    logic [6:0]  lead_reg, lead_next;

    logic        accept;
    logic        fire;
    logic        produce;
    sjis_char_t  result;
    logic        do_plain;
    logic [7:0]  b;
    logic        gr;
    logic [7:0]  gset;
    logic [6:0]  c;
    logic [1:0]  tgt;

    assign fire       = in_valid_reg && (!out_valid_reg || !char_stall);
    assign byte_stall = in_valid_reg && !fire;
    assign accept     = byte_valid && !byte_stall;
    assign char_valid = out_valid_reg;
    assign char_data  = out_data_reg;

    assign b    = in_data_reg.in_byte;
    assign gr   = b[7];
    assign c    = b[6:0];
    assign gset = gr ? right_set_reg : left_set_reg;
    assign tgt  = 2'(b - ESC_DESIG_G0);

    always_comb
    begin
        desig_next        = desig_reg;
        left_set_next     = left_set_reg;
        right_set_next    = right_set_reg;
        saved_left_next   = saved_left_reg;
        single_shift_next = single_shift_reg;
        esc_stage_next    = esc_stage_reg;
        esc_target_next   = esc_target_reg;
        pend_next         = pend_reg;
        lead_next         = lead_reg;
        produce           = 1'b0;
        result            = '{first_out: 8'h00, second_out: 8'h00, byte_count: 2'd1};
        do_plain          = 1'b0;

        if (pend_reg == PEND_KANJI)
        begin
            pend_next = PEND_NONE;
            produce   = 1'b1;
            result    = kanji(lead_reg, b);
        end
        else if (pend_reg != PEND_NONE)
        begin
            pend_next = PEND_NONE;
        end
        else
        begin
            esc_stage_next = ESC_IDLE;
            case (esc_stage_reg)
                ESC_IDLE: do_plain = 1'b1;
                ESC_AFTER:
                begin
                    case (b)
                        ESC_LS2:  left_set_next  = desig_reg[2];
                        ESC_LS3:  left_set_next  = desig_reg[3];
                        ESC_LS1R: right_set_next = desig_reg[1];
                        ESC_LS2R: right_set_next = desig_reg[2];
                        ESC_LS3R: right_set_next = desig_reg[3];
                        ESC_DESIG_G0, ESC_DESIG_G1, ESC_DESIG_G2, ESC_DESIG_G3:
                        begin
                            esc_target_next = tgt;
                            esc_stage_next  = ESC_FINAL;
                        end
                        ESC_MULTIBYTE: esc_stage_next = ESC_MULTI;
                        default: do_plain = 1'b1;
                    endcase
                end
                ESC_FINAL:
                begin
                    if (b == ESC_DRCS)
                    begin
                        esc_stage_next = ESC_SKIP;
                    end
                    else if (set_valid(b))
                    begin
                        desig_next[esc_target_reg] = b;
                    end
                end
                ESC_MULTI:
                begin
                    if (b == ESC_DESIG_G1 || b == ESC_DESIG_G2 || b == ESC_DESIG_G3)
                    begin
                        esc_target_next = tgt;
                        esc_stage_next  = ESC_FINAL;
                    end
                    else if (set_valid(b))
                    begin
                        desig_next[0] = b;
                    end
                end
                default: esc_stage_next = ESC_IDLE;
            endcase
        end

        if (do_plain)
        begin
            case (b)
                CODE_LS0: left_set_next = desig_reg[0];
                CODE_LS1: left_set_next = desig_reg[1];
                CODE_SS2, CODE_SS3:
                begin
                    saved_left_next   = left_set_reg;
                    left_set_next     = (b == CODE_SS2) ? desig_reg[2] : desig_reg[3];
                    single_shift_next = 1'b1;
                end
                CODE_ESC: esc_stage_next = ESC_AFTER;
                default:
                begin
                    if (!(b <= CODE_SPACE || b == CODE_DEL || (b >= 8'h80 && b <= 8'hA0) ||
                          b == 8'hFF))
                    begin
                        case (gset)
                            SET_KANJI, SET_JIS_KANJI1, SET_JIS_KANJI2:
                            begin
                                if (!gr)
                                begin
                                    pend_next = PEND_KANJI;
                                    lead_next = c;
                                end
                            end
                            SET_ASCII, SET_PROP_ALNUM:
                            begin
                                produce = 1'b1;
                                result  = '{first_out: {1'b0, c}, second_out: 8'h00,
                                            byte_count: 2'd1};
                            end
                            SET_HIRAGANA, SET_PROP_HIRA:
                            begin
                                produce = 1'b1;
                                result  = kana(c, 1'b0);
                            end
                            SET_KATAKANA, SET_PROP_KATA, SET_JISX_KATA:
                            begin
                                produce = 1'b1;
                                result  = kana(c, 1'b1);
                            end
                            SET_ADD_SYMBOL:
                            begin
                                pend_next = PEND_SYMBOL;
                                produce   = 1'b1;
                                result    = '{first_out: SJIS_SYM_LEAD,
                                              second_out: SJIS_QUESTION, byte_count: 2'd2};
                            end
                            default: produce = 1'b0;
                        endcase
                        if (single_shift_reg)
                        begin
                            left_set_next     = saved_left_reg;
                            single_shift_next = 1'b0;
                        end
                    end
                end
            endcase
        end

        if (in_data_reg.end_of_string)
        begin
            desig_next[0]     = SET_KANJI;
            desig_next[1]     = SET_ASCII;
            desig_next[2]     = SET_HIRAGANA;
            desig_next[3]     = SET_KATAKANA;
            left_set_next     = SET_KANJI;
            right_set_next    = SET_HIRAGANA;
            saved_left_next   = 8'h00;
            single_shift_next = 1'b0;
            esc_stage_next    = ESC_IDLE;
            esc_target_next   = 2'd0;
            pend_next         = PEND_NONE;
            lead_next         = 7'h00;
        end
    end

    always_comb
    begin
        in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        in_data_next   = accept ? byte_data : in_data_reg;
        out_valid_next = (fire && produce) ? 1'b1 : (char_stall ? out_valid_reg : 1'b0);
        out_data_next  = (fire && produce) ? result : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            desig_reg[0]     <= SET_KANJI;
            desig_reg[1]     <= SET_ASCII;
            desig_reg[2]     <= SET_HIRAGANA;
            desig_reg[3]     <= SET_KATAKANA;
            left_set_reg     <= SET_KANJI;
            right_set_reg    <= SET_HIRAGANA;
            saved_left_reg   <= 8'h00;
            single_shift_reg <= 1'b0;
            esc_stage_reg    <= ESC_IDLE;
            esc_target_reg   <= 2'd0;
            pend_reg         <= PEND_NONE;
            lead_reg         <= 7'h00;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                desig_reg        <= desig_next;
                left_set_reg     <= left_set_next;
                right_set_reg    <= right_set_next;
                saved_left_reg   <= saved_left_next;
                single_shift_reg <= single_shift_next;
                esc_stage_reg    <= esc_stage_next;
                esc_target_reg   <= esc_target_next;
                pend_reg         <= pend_next;
                lead_reg         <= lead_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    // A result always holds one or two bytes, and a single byte has no second byte.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_data.byte_count == 2'd1 || char_data.byte_count == 2'd2))
        else $error("result byte count out of range");

    a_single_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_data.byte_count == 2'd1) |-> char_data.second_out == 8'h00)
        else $error("single-byte result carries a second byte");

    // The input side only stalls while a request is held and cannot move on.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (in_valid_reg && out_valid_reg && char_stall))
        else $error("input stalled without a blocked request");

    // The end of a string leaves no escape, shift or trail byte pending.
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_data_reg.end_of_string) |=>
            (esc_stage_reg == ESC_IDLE && pend_reg == PEND_NONE && !single_shift_reg &&
             left_set_reg == SET_KANJI && right_set_reg == SET_HIRAGANA))
        else $error("state not cleared after end of string");

    // A kanji trail byte always completes a two-byte result.
    a_kanji_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pend_reg == PEND_KANJI) |=>
            (char_valid && char_data.byte_count == 2'd2 && pend_reg == PEND_NONE))
        else $error("kanji trail byte did not produce a character");

endmodule
